// ----- hdl/line_escape_motion_controller_macros.svh -----
// Assertion macros for the line escape motion controller checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LINE_ESCAPE_MOTION_CONTROLLER_MACROS_SVH
`define LINE_ESCAPE_MOTION_CONTROLLER_MACROS_SVH

// same-cycle implication
`define LEMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lemc: assertion failed");

// next-cycle implication
`define LEMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lemc: assertion failed");

`endif

// ----- hdl/lemc_pkg.sv -----
// Shared types, constants and coefficient table for the line escape motion controller.
// No dependencies; used by lemc_qmul and line_escape_motion_controller.
package lemc_pkg;

	localparam int MOT_W  = 16;
	localparam int QFRAC  = 12;
	localparam int PROD_W = 18;
	localparam int AREA_W = 18;
	localparam int REG_W  = 16;
	localparam int TICK_W = 7;
	localparam int DIST_W = 8;

	localparam logic [TICK_W-1:0] TICK_ARM_LIM   = 7'd8;
	localparam logic [TICK_W-1:0] TICK_DAMP_LIM  = 7'd85;
	localparam logic [TICK_W-1:0] TICK_CLEAR_LIM = 7'd120;
	localparam logic [TICK_W-1:0] TICK_MAX       = 7'd127;
	localparam logic [DIST_W-1:0] NEAR_DIST      = 8'd11;

	localparam logic signed [MOT_W-1:0] FIX_M0P65 = -16'sd2662;
	localparam logic signed [MOT_W-1:0] FIX_P0P65 = 16'sd2662;
	localparam logic signed [MOT_W-1:0] FIX_M0P70 = -16'sd2867;
	localparam logic signed [MOT_W-1:0] FIX_P0P70 = 16'sd2867;

	localparam logic signed [PROD_W-1:0] SAT_MAX = 18'sd32767;
	localparam logic signed [PROD_W-1:0] SAT_MIN = -18'sd32768;

	localparam logic CFG_ARMED    = 1'b0;
	localparam logic CFG_KEEP_OUT = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ON_X,
		S_ON_Y,
		S_ON_FIX,
		S_F_DRAIN,
		S_F_X,
		S_F_Y,
		S_B_DRAIN,
		S_B_X,
		S_B_Y,
		S_R_DRAIN,
		S_R_Y,
		S_R_X,
		S_L_DRAIN,
		S_L_Y,
		S_L_X,
		S_OFF_FIN,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		COEF_M1P20,
		COEF_M0P80,
		COEF_M0P65,
		COEF_P1P20,
		COEF_M0P70,
		COEF_P0P70,
		COEF_P0P40,
		COEF_P1P25,
		COEF_P0P50,
		COEF_P0P65
	} coef_t;

	typedef struct packed {
		logic  use_y;
		coef_t coef;
	} mul_ctrl_t;

	function automatic logic signed [MOT_W-1:0] coef_value(coef_t c);
		logic signed [MOT_W-1:0] v;
		case (c)
			COEF_M1P20: v = -16'sd4915;
			COEF_M0P80: v = -16'sd3277;
			COEF_M0P65: v = -16'sd2662;
			COEF_P1P20: v = 16'sd4915;
			COEF_M0P70: v = -16'sd2867;
			COEF_P0P70: v = 16'sd2867;
			COEF_P0P40: v = 16'sd1638;
			COEF_P1P25: v = 16'sd5120;
			COEF_P0P50: v = 16'sd2048;
			COEF_P0P65: v = 16'sd2662;
			default:    v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/lemc_qmul.sv -----
// Shared Q3.12 constant multiplier: operand select, floor shift and saturation.
// Depends on lemc_pkg.
module lemc_qmul (
	input  logic signed [lemc_pkg::MOT_W-1:0]  x_op,
	input  logic signed [lemc_pkg::MOT_W-1:0]  y_op,
	input  lemc_pkg::mul_ctrl_t                ctrl,
	output logic signed [lemc_pkg::PROD_W-1:0] prod,
	output logic signed [lemc_pkg::MOT_W-1:0]  prod_sat
);

	logic signed [lemc_pkg::MOT_W-1:0]   op;
	logic signed [2*lemc_pkg::MOT_W-1:0] full;

	assign op   = ctrl.use_y ? y_op : x_op;
	assign full = op * lemc_pkg::coef_value(ctrl.coef);
	// arithmetic shift, result always fits PROD_W
	assign prod = full[lemc_pkg::QFRAC+lemc_pkg::PROD_W-1:lemc_pkg::QFRAC];

	always_comb begin
		if (prod > lemc_pkg::SAT_MAX) begin
			prod_sat = lemc_pkg::SAT_MAX[lemc_pkg::MOT_W-1:0];
		end else if (prod < lemc_pkg::SAT_MIN) begin
			prod_sat = lemc_pkg::SAT_MIN[lemc_pkg::MOT_W-1:0];
		end else begin
			prod_sat = prod[lemc_pkg::MOT_W-1:0];
		end
	end

endmodule

// ----- hdl/line_escape_motion_controller.sv -----
// On-line requests step ON_X, ON_Y, ON_FIX; off-line requests step the four drain checks
// and OFF_FIN, plus X and Y steps per drain taken (at most two per request); then DONE.
// Throughput: one request at a time; in_ready returns the cycle the result is registered.
// A result stalled on out_ready holds the sequencer in its final state.
// A single shared multiplier is stepped by the sequencer.
// Reset (arst_n low, asynchronous): tick count and areas clear, levels load defaults.
module line_escape_motion_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [lemc_pkg::REG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                on_line,
	input  logic                                front_level,
	input  logic                                back_level,
	input  logic                                right_level,
	input  logic                                left_level,
	input  logic signed [lemc_pkg::MOT_W-1:0]   move_x,
	input  logic signed [lemc_pkg::MOT_W-1:0]   move_y,
	input  logic [lemc_pkg::DIST_W-1:0]         ir_distance,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lemc_pkg::MOT_W-1:0]   drive_x,
	output logic signed [lemc_pkg::MOT_W-1:0]   drive_y
);

	lemc_pkg::state_t state_q, state_nxt;
	lemc_pkg::mul_ctrl_t mul_ctrl;

	logic [lemc_pkg::REG_W-1:0]          armed_q, keep_q;
	logic [lemc_pkg::TICK_W-1:0]         ticks_q;
	logic signed [lemc_pkg::AREA_W-1:0]  front_q, back_q, right_q, left_q;
	logic signed [lemc_pkg::MOT_W-1:0]   x_q, y_q, drive_x_q, drive_y_q;
	logic                                see_f_q, see_b_q, see_r_q, see_l_q, near_q;
	logic                                out_valid_q;

	logic signed [lemc_pkg::PROD_W-1:0]  prod;
	logic signed [lemc_pkg::MOT_W-1:0]   prod_sat;
	logic signed [lemc_pkg::AREA_W-1:0]  arm_s, ko_s;
	logic signed [lemc_pkg::MOT_W-1:0]   fx1, fx2, fy1, fy2;
	logic                                accept, load_out, early, damp;
	logic                                f_cond, b_cond, r_cond, l_cond;

	lemc_qmul u_qmul (
		.x_op     (x_q),
		.y_op     (y_q),
		.ctrl     (mul_ctrl),
		.prod     (prod),
		.prod_sat (prod_sat)
	);

	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == lemc_pkg::S_DONE) && (!out_valid_q || out_ready);
	assign early    = ticks_q < lemc_pkg::TICK_ARM_LIM;
	assign damp     = ticks_q < lemc_pkg::TICK_DAMP_LIM;
	assign arm_s    = {{(lemc_pkg::AREA_W-lemc_pkg::REG_W){1'b0}}, armed_q};
	assign ko_s     = {{(lemc_pkg::AREA_W-lemc_pkg::REG_W){1'b0}}, keep_q};

	assign f_cond = (front_q > 0) && (y_q < 0);
	assign b_cond = (back_q > 0) && (y_q > 0);
	assign r_cond = (right_q > 0) && (x_q < 0);
	assign l_cond = (left_q > 0) && (x_q > 0);

	// on-line push-back overrides, applied in order
	always_comb begin
		fy1 = ((front_q > 0) && (y_q > 0)) ? lemc_pkg::FIX_M0P65 : y_q;
		fy2 = ((back_q > 0) && (fy1 < 0)) ? lemc_pkg::FIX_P0P65 : fy1;
		fx1 = ((right_q > 0) && (x_q > 0)) ? lemc_pkg::FIX_M0P70 : x_q;
		fx2 = ((left_q > 0) && (fx1 < 0)) ? lemc_pkg::FIX_P0P70 : fx1;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lemc_pkg::S_IDLE:    if (accept) state_nxt = on_line ? lemc_pkg::S_ON_X
									: lemc_pkg::S_F_DRAIN;
			lemc_pkg::S_ON_X:    state_nxt = lemc_pkg::S_ON_Y;
			lemc_pkg::S_ON_Y:    state_nxt = lemc_pkg::S_ON_FIX;
			lemc_pkg::S_ON_FIX:  state_nxt = lemc_pkg::S_DONE;
			lemc_pkg::S_F_DRAIN: state_nxt = f_cond ? lemc_pkg::S_F_X : lemc_pkg::S_B_DRAIN;
			lemc_pkg::S_F_X:     state_nxt = lemc_pkg::S_F_Y;
			lemc_pkg::S_F_Y:     state_nxt = lemc_pkg::S_B_DRAIN;
			lemc_pkg::S_B_DRAIN: state_nxt = b_cond ? lemc_pkg::S_B_X : lemc_pkg::S_R_DRAIN;
			lemc_pkg::S_B_X:     state_nxt = lemc_pkg::S_B_Y;
			lemc_pkg::S_B_Y:     state_nxt = lemc_pkg::S_R_DRAIN;
			lemc_pkg::S_R_DRAIN: state_nxt = r_cond ? lemc_pkg::S_R_Y : lemc_pkg::S_L_DRAIN;
			lemc_pkg::S_R_Y:     state_nxt = lemc_pkg::S_R_X;
			lemc_pkg::S_R_X:     state_nxt = lemc_pkg::S_L_DRAIN;
			lemc_pkg::S_L_DRAIN: state_nxt = l_cond ? lemc_pkg::S_L_Y : lemc_pkg::S_OFF_FIN;
			lemc_pkg::S_L_Y:     state_nxt = lemc_pkg::S_L_X;
			lemc_pkg::S_L_X:     state_nxt = lemc_pkg::S_OFF_FIN;
			lemc_pkg::S_OFF_FIN: state_nxt = lemc_pkg::S_DONE;
			lemc_pkg::S_DONE:    if (load_out) state_nxt = lemc_pkg::S_IDLE;
			default:             state_nxt = lemc_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready       = (state_q == lemc_pkg::S_IDLE);
		mul_ctrl.use_y = 1'b0;
		mul_ctrl.coef  = lemc_pkg::COEF_P0P50;
		case (state_q)
			lemc_pkg::S_ON_X: begin
				mul_ctrl.coef = early ? lemc_pkg::COEF_M1P20 : lemc_pkg::COEF_M0P80;
			end
			lemc_pkg::S_ON_Y: begin
				mul_ctrl.use_y = 1'b1;
				mul_ctrl.coef  = early ? lemc_pkg::COEF_M0P80 : lemc_pkg::COEF_M0P65;
			end
			lemc_pkg::S_F_DRAIN: begin
				mul_ctrl.use_y = 1'b1;
				mul_ctrl.coef  = lemc_pkg::COEF_M1P20;
			end
			lemc_pkg::S_F_X, lemc_pkg::S_B_X: begin
				mul_ctrl.coef = lemc_pkg::COEF_P0P40;
			end
			lemc_pkg::S_F_Y, lemc_pkg::S_B_Y: begin
				mul_ctrl.use_y = 1'b1;
				mul_ctrl.coef  = lemc_pkg::COEF_P1P25;
			end
			lemc_pkg::S_B_DRAIN: begin
				mul_ctrl.use_y = 1'b1;
				mul_ctrl.coef  = lemc_pkg::COEF_P1P20;
			end
			lemc_pkg::S_R_DRAIN: begin
				mul_ctrl.coef = lemc_pkg::COEF_M0P70;
			end
			lemc_pkg::S_L_DRAIN: begin
				mul_ctrl.coef = lemc_pkg::COEF_P0P70;
			end
			lemc_pkg::S_R_Y, lemc_pkg::S_L_Y: begin
				mul_ctrl.use_y = 1'b1;
				mul_ctrl.coef  = lemc_pkg::COEF_P0P50;
			end
			lemc_pkg::S_R_X, lemc_pkg::S_L_X: begin
				mul_ctrl.coef = lemc_pkg::COEF_P0P65;
			end
			default: begin
				mul_ctrl.use_y = 1'b0;
			end
		endcase
	end

	// control state, levels and escape areas
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lemc_pkg::S_IDLE;
			armed_q     <= 16'd4096;
			keep_q      <= 16'd2048;
			ticks_q     <= '0;
			front_q     <= '0;
			back_q      <= '0;
			right_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					lemc_pkg::CFG_ARMED:    armed_q <= cfg_data;
					lemc_pkg::CFG_KEEP_OUT: keep_q  <= cfg_data;
					default:                armed_q <= armed_q;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (!on_line) begin
					ticks_q <= '0;
				end else if (ticks_q != lemc_pkg::TICK_MAX) begin
					ticks_q <= ticks_q + 1'b1;
				end
			end
			case (state_q)
				lemc_pkg::S_ON_X: begin
					if (early) begin
						if (see_f_q && front_q < arm_s) front_q <= arm_s;
						if (see_b_q && back_q < arm_s)  back_q  <= arm_s;
						if (see_r_q && right_q < arm_s) right_q <= arm_s;
						if (see_l_q && left_q < arm_s)  left_q  <= arm_s;
					end
				end
				lemc_pkg::S_ON_FIX: begin
					if (ticks_q > lemc_pkg::TICK_CLEAR_LIM) begin
						front_q <= '0;
						back_q  <= '0;
						right_q <= '0;
						left_q  <= '0;
					end
				end
				lemc_pkg::S_F_DRAIN: if (f_cond) front_q <= front_q - prod;
				lemc_pkg::S_B_DRAIN: if (b_cond) back_q  <= back_q - prod;
				lemc_pkg::S_R_DRAIN: if (r_cond) right_q <= right_q - prod;
				lemc_pkg::S_L_DRAIN: if (l_cond) left_q  <= left_q - prod;
				lemc_pkg::S_OFF_FIN: begin
					if (near_q || front_q < 0) front_q <= '0;
					if (near_q || back_q < 0)  back_q  <= '0;
					if (near_q || right_q < 0) right_q <= '0;
					if (near_q || left_q < 0)  left_q  <= '0;
				end
				default: begin
					front_q <= front_q;
				end
			endcase
		end
	end

	// motion payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= move_x;
			y_q     <= move_y;
			see_f_q <= !front_level;
			see_b_q <= !back_level;
			see_r_q <= !right_level;
			see_l_q <= !left_level;
			near_q  <= ir_distance < lemc_pkg::NEAR_DIST;
		end
		if (load_out) begin
			drive_x_q <= x_q;
			drive_y_q <= y_q;
		end
		case (state_q)
			lemc_pkg::S_ON_X: if (damp) x_q <= prod_sat;
			lemc_pkg::S_ON_Y: if (damp) y_q <= prod_sat;
			lemc_pkg::S_ON_FIX: begin
				if (!early) begin
					x_q <= fx2;
					y_q <= fy2;
				end
			end
			lemc_pkg::S_F_X, lemc_pkg::S_B_X, lemc_pkg::S_R_X, lemc_pkg::S_L_X: begin
				x_q <= prod_sat;
			end
			lemc_pkg::S_F_Y, lemc_pkg::S_B_Y, lemc_pkg::S_R_Y, lemc_pkg::S_L_Y: begin
				y_q <= prod_sat;
			end
			lemc_pkg::S_OFF_FIN: begin
				if (front_q > ko_s || back_q > ko_s) y_q <= '0;
				if (right_q > ko_s || left_q > ko_s) x_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign drive_x   = drive_x_q;
	assign drive_y   = drive_y_q;

endmodule

// ----- hdl/lemc_checker.sv -----
// Port-level checker for line_escape_motion_controller, attached by bind.
// Depends on line_escape_motion_controller_macros.svh and lemc_pkg.
`include "line_escape_motion_controller_macros.svh"

module lemc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [lemc_pkg::MOT_W-1:0] drive_x,
	input logic signed [lemc_pkg::MOT_W-1:0] drive_y
);

	logic in_accept, out_stall;

	assign in_accept = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// result held while stalled
	`LEMC_ASSERT_NEXT(a_out_hold_x, clk, arst_n, out_stall, out_valid && $stable(drive_x))
	`LEMC_ASSERT_NEXT(a_out_hold_y, clk, arst_n, out_stall, $stable(drive_y))

	// busy right after a request is accepted
	`LEMC_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_accept, !in_ready ##1 !in_ready)

	// a new result only appears at the end of a busy period
	`LEMC_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind line_escape_motion_controller lemc_checker u_lemc_checker (.*);

// ----- verif/tb_line_escape_motion_controller.sv -----
`timescale 1ns / 1ps
// Testbench for the line escape motion controller: directed and random requests
// against a built-in predictor of the escape areas and motion adjustment.
// Depends on lemc_pkg and line_escape_motion_controller.
module tb_line_escape_motion_controller;

	localparam int K_M1P20 = -4915;
	localparam int K_M0P80 = -3277;
	localparam int K_M0P65 = -2662;
	localparam int K_P0P65 = 2662;
	localparam int K_M0P70 = -2867;
	localparam int K_P0P70 = 2867;
	localparam int K_P1P20 = 4915;
	localparam int K_P1P25 = 5120;
	localparam int K_P0P40 = 1638;
	localparam int K_P0P50 = 2048;
	localparam int TICK_SAT = 127;
	localparam int NEAR_LIM = 11;
	localparam int WATCHDOG_LIM = 4000;
	localparam int PHASE_REQS = 275;

	typedef struct packed {
		logic                     on;
		logic                     f_lvl;
		logic                     b_lvl;
		logic                     r_lvl;
		logic                     l_lvl;
		logic signed [15:0]       mx;
		logic signed [15:0]       my;
		logic [7:0]               ir_dist;
	} motion_req_t;

	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} drive_t;

	class escape_scoreboard;
		int arm_level;
		int keep_out;
		int ticks;
		int area_f, area_b, area_r, area_l;
		drive_t drive_q[$];
		int errors;

		function new();
			arm_level = 4096;
			keep_out  = 2048;
			ticks     = 0;
			errors    = 0;
			clear_areas();
		endfunction

		function void clear_areas();
			area_f = 0;
			area_b = 0;
			area_r = 0;
			area_l = 0;
		endfunction

		function int fx_mul(int a, int c);
			longint p;
			p = longint'(a) * longint'(c);
			return int'(p >>> 12);
		endfunction

		function int sat_mul(int a, int c);
			int v;
			v = fx_mul(a, c);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v;
		endfunction

		function void set_level(logic idx, int v);
			if (idx == lemc_pkg::CFG_ARMED) arm_level = v;
			else keep_out = v;
		endfunction

		function int pending();
			return drive_q.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function void note_request(motion_req_t r);
			int x, y;
			drive_t d;
			x = r.mx;
			y = r.my;
			if (r.on) begin
				if (ticks < TICK_SAT) ticks++;
				if (ticks < 8) begin
					x = sat_mul(x, K_M1P20);
					y = sat_mul(y, K_M0P80);
					if (!r.f_lvl && area_f < arm_level) area_f = arm_level;
					if (!r.b_lvl && area_b < arm_level) area_b = arm_level;
					if (!r.r_lvl && area_r < arm_level) area_r = arm_level;
					if (!r.l_lvl && area_l < arm_level) area_l = arm_level;
				end else begin
					if (ticks < 85) begin
						x = sat_mul(x, K_M0P80);
						y = sat_mul(y, K_M0P65);
					end
					if (area_f > 0 && y > 0) y = K_M0P65;
					if (area_b > 0 && y < 0) y = K_P0P65;
					if (area_r > 0 && x > 0) x = K_M0P70;
					if (area_l > 0 && x < 0) x = K_P0P70;
				end
				if (ticks > 120) clear_areas();
			end else begin
				ticks = 0;
				if (area_f > 0 && y < 0) begin
					area_f -= fx_mul(y, K_M1P20);
					x = sat_mul(x, K_P0P40);
					y = sat_mul(y, K_P1P25);
				end
				if (area_b > 0 && y > 0) begin
					area_b -= fx_mul(y, K_P1P20);
					x = sat_mul(x, K_P0P40);
					y = sat_mul(y, K_P1P25);
				end
				if (area_r > 0 && x < 0) begin
					area_r -= fx_mul(x, K_M0P70);
					y = sat_mul(y, K_P0P50);
					x = sat_mul(x, K_P0P65);
				end
				if (area_l > 0 && x > 0) begin
					area_l -= fx_mul(x, K_P0P70);
					y = sat_mul(y, K_P0P50);
					x = sat_mul(x, K_P0P65);
				end
				if (area_f > keep_out || area_b > keep_out) y = 0;
				if (area_r > keep_out || area_l > keep_out) x = 0;
				if (r.ir_dist < NEAR_LIM) clear_areas();
				if (area_l < 0) area_l = 0;
				if (area_r < 0) area_r = 0;
				if (area_f < 0) area_f = 0;
				if (area_b < 0) area_b = 0;
			end
			d.dx = x[15:0];
			d.dy = y[15:0];
			drive_q.push_back(d);
		endfunction

		function void check_result(logic signed [15:0] x, logic signed [15:0] y);
			drive_t e;
			if (drive_q.size() == 0) begin
				flag($sformatf("unexpected drive result x=%0d y=%0d", x, y));
				return;
			end
			e = drive_q.pop_front();
			if (e.dx !== x || e.dy !== y)
				flag($sformatf("drive error: expected x=%0d y=%0d, got x=%0d y=%0d",
					e.dx, e.dy, x, y));
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_index = '0;
	logic [lemc_pkg::REG_W-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                on_line = 1'b0;
	logic                front_level = 1'b1;
	logic                back_level = 1'b1;
	logic                right_level = 1'b1;
	logic                left_level = 1'b1;
	logic signed [lemc_pkg::MOT_W-1:0] move_x = '0;
	logic signed [lemc_pkg::MOT_W-1:0] move_y = '0;
	logic [lemc_pkg::DIST_W-1:0] ir_distance = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [lemc_pkg::MOT_W-1:0] drive_x;
	logic signed [lemc_pkg::MOT_W-1:0] drive_y;

	escape_scoreboard sb = new();
	int req_count = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	logic [15:0] rx_cycle = '0;
	logic [1:0] rx_mode = '0;

	line_escape_motion_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.on_line(on_line),
		.front_level(front_level),
		.back_level(back_level),
		.right_level(right_level),
		.left_level(left_level),
		.move_x(move_x),
		.move_y(move_y),
		.ir_distance(ir_distance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_x(drive_x),
		.drive_y(drive_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(drive_x, drive_y);
		rx_cycle <= rx_cycle + 16'd1;
		if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
		case (rx_mode)
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (rx_cycle[2:0] == 3'd0);
			default: out_ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIM) begin
			$display("line_escape_motion_controller: mismatch");
			$finish;
		end
	end

	function automatic motion_req_t mk(logic on, logic f, logic b, logic r, logic l,
			int x, int y, int d);
		motion_req_t q;
		q.on      = on;
		q.f_lvl   = f;
		q.b_lvl   = b;
		q.r_lvl   = r;
		q.l_lvl   = l;
		q.mx      = x[15:0];
		q.my      = y[15:0];
		q.ir_dist = d[7:0];
		return q;
	endfunction

	function automatic int rand_motion();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3, 4: return int'($urandom_range(0, 8191)) - 4096;
			5: return int'($urandom_range(0, 511)) - 256;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	function automatic int rand_dist();
		if ($urandom_range(0, 14) == 0) return $urandom_range(0, 10);
		return $urandom_range(11, 255);
	endfunction

	// request stays valid until accepted; gaps between random-length bursts
	task automatic send_req(motion_req_t r);
		int gap;
		in_valid    <= 1'b1;
		on_line     <= r.on;
		front_level <= r.f_lvl;
		back_level  <= r.b_lvl;
		right_level <= r.r_lvl;
		left_level  <= r.l_lvl;
		move_x      <= r.mx;
		move_y      <= r.my;
		ir_distance <= r.ir_dist;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
		req_count++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_level(logic idx, int v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_level(idx, v);
		@(posedge clk);
	endtask

	// one line contact followed by an escape run; some episodes are pure noise
	task automatic run_episode();
		int on_len, off_len;
		logic [3:0] mask;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 10))
				send_req(mk(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
					1'($urandom), rand_motion(), rand_motion(), $urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3: on_len = $urandom_range(1, 7);
			4, 5, 6, 7: on_len = $urandom_range(8, 90);
			default: on_len = $urandom_range(110, 135);
		endcase
		off_len = $urandom_range(1, 25);
		mask = 4'($urandom);
		repeat (on_len) begin
			if ($urandom_range(0, 5) == 0) mask = 4'($urandom);
			send_req(mk(1'b1, mask[3], mask[2], mask[1], mask[0],
				rand_motion(), rand_motion(), $urandom_range(0, 255)));
		end
		repeat (off_len)
			send_req(mk(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				rand_motion(), rand_motion(), rand_dist()));
	endtask

	initial begin
		int phase_end;
		int arm_v, ko_v;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// arming on first contact, saturation, each side draining, clamp below zero
		send_req(mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, -32768, -32768, 255));
		send_req(mk(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32767, 32767, 0));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 0, -32768, 200));
		send_req(mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32767, 32767, 200));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, -32768, 100, 200));
		// near obstacle clears, just below and at the threshold
		send_req(mk(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 500, -500, 255));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 0, 0, 10));
		send_req(mk(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 0, 0, 255));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, -100, -100, 11));
		// keep-out cancel, then gradual drain out of the zone
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1000, 1000, 255));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, -1000, 1000, 255));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 32767, -32768, 255));
		// damped phase with the per-side overrides
		send_req(mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 255));
		repeat (9) send_req(mk(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, rand_motion(), rand_motion(), 128));
		send_req(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 32767, 32767, 0));
		drain_all();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin arm_v = 65535; ko_v = 0; end
				1: begin arm_v = 0; ko_v = 65535; end
				2: begin arm_v = 4096; ko_v = 2048; end
				3: begin arm_v = 65535; ko_v = 65535; end
				4: begin arm_v = $urandom_range(0, 65535); ko_v = $urandom_range(0, 65535); end
				default: begin arm_v = $urandom_range(1, 8192); ko_v = $urandom_range(0, 4096); end
			endcase
			write_level(lemc_pkg::CFG_ARMED, arm_v);
			write_level(lemc_pkg::CFG_KEEP_OUT, ko_v);
			phase_end = req_count + PHASE_REQS;
			while (req_count < phase_end) run_episode();
			drain_all();
		end

		if (sb.pending() != 0) sb.flag("drive results missing at end of run");
		if (sb.errors == 0) begin
			$display("line_escape_motion_controller: match");
		end else begin
			$display("line_escape_motion_controller: mismatch");
		end
		$finish;
	end

endmodule
